// File: rtl/dlf_pkg.sv
// Package for the dense layer forward block: sizes, operation codes, register indexes.
// Depends on nothing; the interface, top-level, checker and testbench files use it.
package dlf_pkg;
  localparam int MaxInputs  = 64;
  localparam int MaxOutputs = 64;
  localparam int WeightDepth = MaxInputs * MaxOutputs;
  localparam int InBits  = $clog2(MaxInputs);
  localparam int OutBits = $clog2(MaxOutputs);
  localparam int WBits   = $clog2(WeightDepth);

  typedef logic [1:0] op_t;
  localparam op_t OP_WEIGHT   = 2'd0;
  localparam op_t OP_BIAS     = 2'd1;
  localparam op_t OP_INPUT    = 2'd2;
  localparam op_t OP_RESERVED = 2'd3;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_MODE = 2'd0;
  localparam cfg_idx_t REG_NIN  = 2'd1;
  localparam cfg_idx_t REG_NOUT = 2'd2;

  typedef struct packed {
    op_t         operation;
    logic [11:0] index;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  neuron_index;
    logic [14:0] activation;
    logic        last_output;
  } out_item_t;

  typedef struct packed {
    cfg_idx_t    index;
    logic [6:0]  data;
  } cfg_item_t;
endpackage

// File: rtl/dlf_if.sv
// Valid/ready channel interfaces, each carrying one payload type.
// Depends on dlf_pkg for the payload types.
interface dlf_in_if;
  logic valid;
  logic ready;
  dlf_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dlf_out_if;
  logic valid;
  logic ready;
  dlf_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dlf_cfg_if;
  logic valid;
  logic ready;
  dlf_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/dlf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module dlf_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/dlf_div.sv
// Restoring divider, one quotient bit per cycle: q = (num) / den, 32-bit unsigned.
// Depends on nothing.
module dlf_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] trial;

  // One shift and subtract step per cycle.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[31]} - {1'b0, den};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

// File: rtl/dense_layer_forward.sv
// Top level of the dense layer forward block: stores, sequencer and shared MAC.
// Depends on dlf_pkg, the dlf_*_if interfaces, dlf_ram and dlf_div.
//
//  channel | direction | beat carries
//  in_     | sink      | operation, index, value
//  out_    | source    | neuron_index, activation, last_output
//  cfg_    | sink      | register index, write data
//
// The last input element starts a pass: one shared multiply-accumulate computes
// every neuron, and softmax adds a max scan, an exp pass and a divide for each neuron.
// Results leave through one output register; the sequencer waits while it is full.
// Reset is synchronous and clears only control state and the registers.
module dense_layer_forward (
  input  logic       clk,
  input  logic       rst_n,
  dlf_in_if.sink     in_ch,
  dlf_out_if.source  out_ch,
  dlf_cfg_if.sink    cfg_ch
);
  import dlf_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MRD   = 4'd1;
  localparam logic [3:0] S_MAC   = 4'd2;
  localparam logic [3:0] S_MEND  = 4'd3;
  localparam logic [3:0] S_MWR   = 4'd4;
  localparam logic [3:0] S_XRD   = 4'd5;
  localparam logic [3:0] S_XCMP  = 4'd6;
  localparam logic [3:0] S_ERD   = 4'd7;
  localparam logic [3:0] S_E1    = 4'd8;
  localparam logic [3:0] S_E2    = 4'd9;
  localparam logic [3:0] S_E3    = 4'd10;
  localparam logic [3:0] S_ORD   = 4'd11;
  localparam logic [3:0] S_OACT  = 4'd12;
  localparam logic [3:0] S_ODIV  = 4'd13;
  localparam logic [3:0] S_OPUT  = 4'd14;
  localparam logic [3:0] S_E4    = 4'd15;

  logic [3:0] st_r, st_nxt;
  logic       mode_r;
  logic [6:0] nin_r, nout_r;
  logic [InBits:0]  ni_eff;
  logic [OutBits:0] no_eff;

  // Effective counts saturate into range.
  always_comb begin
    ni_eff = (nin_r == 0) ? (InBits+1)'(1) :
             ((nin_r > MaxInputs) ? (InBits+1)'(MaxInputs) : (InBits+1)'(nin_r));
    no_eff = (nout_r == 0) ? (OutBits+1)'(1) :
             ((nout_r > MaxOutputs) ? (OutBits+1)'(MaxOutputs) : (OutBits+1)'(nout_r));
  end

  // Configuration registers.
  assign cfg_ch.ready = (st_r == S_IDLE);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      nin_r  <= 7'd64;
      nout_r <= 7'd64;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.data.index)
        REG_MODE: mode_r <= cfg_ch.data.data[0];
        REG_NIN:  nin_r  <= cfg_ch.data.data;
        REG_NOUT: nout_r <= cfg_ch.data.data;
        default: ;
      endcase
    end
  end

  // Memories.
  logic             acc_in;
  in_item_t         it;
  logic [WBits-1:0]   w_ra;
  logic [15:0]        w_rd, b_rd, x_rd;
  logic [OutBits-1:0] b_ra, p_ra, p_wa;
  logic [InBits-1:0]  x_ra;
  logic [31:0]        p_rd, p_wd;
  logic               p_we;
  logic [OutBits-1:0] e_ra, e_wa;
  logic [12:0]        e_rd, e_wd;
  logic               e_we;

  assign it     = in_ch.data;
  assign acc_in = in_ch.valid && in_ch.ready;

  dlf_ram #(.Width(16), .Depth(WeightDepth)) u_wram (
    .clk, .we(acc_in && it.operation == OP_WEIGHT && it.index < WeightDepth),
    .waddr(it.index[WBits-1:0]), .wdata(it.value), .raddr(w_ra), .rdata(w_rd));
  dlf_ram #(.Width(16), .Depth(MaxOutputs)) u_bram (
    .clk, .we(acc_in && it.operation == OP_BIAS && it.index < MaxOutputs),
    .waddr(it.index[OutBits-1:0]), .wdata(it.value), .raddr(b_ra), .rdata(b_rd));
  dlf_ram #(.Width(16), .Depth(MaxInputs)) u_xram (
    .clk, .we(acc_in && it.operation == OP_INPUT && it.index < MaxInputs),
    .waddr(it.index[InBits-1:0]), .wdata(it.value), .raddr(x_ra), .rdata(x_rd));
  dlf_ram #(.Width(32), .Depth(MaxOutputs)) u_pram (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  dlf_ram #(.Width(13), .Depth(MaxOutputs)) u_eram (
    .clk, .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));

  // Sequencer registers.
  logic [OutBits:0]   n_r, n_nxt;
  logic [InBits:0]    j_r, j_nxt;
  logic [WBits-1:0]   wa_r, wa_nxt;
  logic signed [47:0] acc_r, acc_nxt;
  logic signed [31:0] prod_r, prod_nxt;
  logic               pv_r, pv_nxt;
  logic signed [31:0] zmax_r, zmax_nxt;
  logic [19:0]        sum_r, sum_nxt;
  logic signed [32:0] d_r, d_nxt;
  logic signed [47:0] t_r, t_nxt;
  logic [11:0]        f_r, f_nxt;
  logic [5:0]         sh_r, sh_nxt;
  logic               zero_r, zero_nxt;
  logic [23:0]        q_r, q_nxt;
  logic               ov_r, ov_nxt;
  out_item_t          res_r, res_nxt;
  logic               div_go;
  logic [31:0]        div_q;
  logic               div_done;

  logic signed [47:0] zfull;
  logic signed [31:0] zsat;
  logic signed [35:0] tk;
  logic [24:0]        pval;

  assign in_ch.ready = (st_r == S_IDLE);
  assign w_ra = wa_r;
  assign x_ra = j_r[InBits-1:0];
  assign b_ra = n_r[OutBits-1:0];
  assign p_ra = n_r[OutBits-1:0];
  assign e_ra = n_r[OutBits-1:0];
  assign p_wa = n_r[OutBits-1:0];
  assign e_wa = n_r[OutBits-1:0];

  dlf_div u_div (.clk, .rst_n, .start(div_go),
    .num({7'd0, e_rd, 12'd0} + {13'd0, sum_r[19:1]}), .den({12'd0, sum_r}),
    .done(div_done), .quo(div_q));

  always_comb begin
    st_nxt = st_r;  n_nxt = n_r;  j_nxt = j_r;  wa_nxt = wa_r;
    acc_nxt = acc_r; prod_nxt = prod_r; pv_nxt = 1'b0;
    zmax_nxt = zmax_r; sum_nxt = sum_r; d_nxt = d_r; t_nxt = t_r;
    f_nxt = f_r; sh_nxt = sh_r; zero_nxt = zero_r; q_nxt = q_r; ov_nxt = ov_r;
    res_nxt = res_r;
    p_we = 1'b0; p_wd = '0; e_we = 1'b0; e_wd = '0; div_go = 1'b0;
    zfull = (acc_r >>> 12) + 48'(signed'(b_rd));
    zsat  = (zfull > 48'sd2147483647) ? 32'sh7fffffff :
            (zfull < -48'sd2147483648) ? 32'sh80000000 : zfull[31:0];
    tk    = t_r[47:12];
    pval  = 25'd0;
    if (out_ch.valid && out_ch.ready) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (acc_in && it.operation == OP_INPUT &&
            it.index == 12'(ni_eff - 1'b1)) begin
          st_nxt = S_MRD; n_nxt = '0; j_nxt = '0; wa_nxt = '0; acc_nxt = '0;
        end
      end
      // Issue reads, one product a cycle through the shared multiplier.
      S_MRD: begin
        st_nxt = S_MAC; j_nxt = j_r + 1'b1; wa_nxt = wa_r + 1'b1;
      end
      S_MAC: begin
        prod_nxt = signed'(w_rd) * signed'(x_rd);
        pv_nxt = 1'b1;
        if (pv_r) acc_nxt = acc_r + 48'(prod_r);
        if (j_r == ni_eff) st_nxt = S_MEND;
        else begin j_nxt = j_r + 1'b1; wa_nxt = wa_r + 1'b1; end
      end
      S_MEND: begin
        acc_nxt = acc_r + 48'(prod_r); st_nxt = S_MWR;
      end
      S_MWR: begin
        p_we = 1'b1; p_wd = zsat; acc_nxt = '0; j_nxt = '0;
        if (n_r == no_eff - 1'b1) begin
          n_nxt = '0; zmax_nxt = 32'sh80000000; sum_nxt = '0;
          st_nxt = mode_r ? S_XRD : S_ORD;
        end else begin
          n_nxt = n_r + 1'b1; st_nxt = S_MRD;
        end
      end
      // Maximum scan.
      S_XRD: st_nxt = S_XCMP;
      S_XCMP: begin
        if (signed'(p_rd) > zmax_r) zmax_nxt = p_rd;
        if (n_r == no_eff - 1'b1) begin n_nxt = '0; st_nxt = S_ERD; end
        else begin n_nxt = n_r + 1'b1; st_nxt = S_XRD; end
      end
      // Exponent approximation, one multiply per cycle.
      S_ERD: st_nxt = S_E1;
      S_E1: begin
        d_nxt = 33'(signed'(p_rd)) - 33'(zmax_r);
        st_nxt = S_E2;
      end
      S_E2: begin
        t_nxt = (48'(d_r) * 48'sd5909) >>> 12;
        st_nxt = S_E3;
      end
      S_E3: begin
        f_nxt = t_r[11:0];
        zero_nxt = (tk < -36'sd13);
        sh_nxt = zero_nxt ? 6'd0 : 6'(-tk);
        q_nxt = 24'({12'd0, t_r[11:0]} * 24'd1407) >> 12;
        st_nxt = S_E4;
      end
      S_E4: begin
        pval = 25'd4096 + 25'((25'(f_r) * (25'd2689 + 25'(q_r))) >> 12);
        e_we = 1'b1;
        e_wd = zero_r ? 13'd0 : 13'(pval >> sh_r);
        sum_nxt = sum_r + 20'(e_wd);
        if (n_r == no_eff - 1'b1) begin n_nxt = '0; st_nxt = S_ORD; end
        else begin n_nxt = n_r + 1'b1; st_nxt = S_ERD; end
      end
      // Output pass.
      S_ORD: if (!ov_r) st_nxt = S_OACT;
      S_OACT: begin
        if (mode_r) begin div_go = 1'b1; st_nxt = S_ODIV; end
        else begin
          res_nxt.activation = (signed'(p_rd) <= 0) ? 15'd0 :
                               (signed'(p_rd) > 32767) ? 15'h7fff : p_rd[14:0];
          st_nxt = S_OPUT;
        end
      end
      S_ODIV: if (div_done) begin
        res_nxt.activation = div_q[14:0]; st_nxt = S_OPUT;
      end
      S_OPUT: begin
        res_nxt.neuron_index = 6'(n_r);
        res_nxt.last_output = (n_r == no_eff - 1'b1);
        ov_nxt = 1'b1;
        if (n_r == no_eff - 1'b1) begin n_nxt = '0; st_nxt = S_IDLE; end
        else begin n_nxt = n_r + 1'b1; st_nxt = S_ORD; end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; pv_r <= 1'b0;
      n_r <= '0; j_r <= '0; wa_r <= '0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; pv_r <= pv_nxt;
      n_r <= n_nxt; j_r <= j_nxt; wa_r <= wa_nxt;
    end
    acc_r <= acc_nxt; prod_r <= prod_nxt; zmax_r <= zmax_nxt; sum_r <= sum_nxt;
    d_r <= d_nxt; t_r <= t_nxt; f_r <= f_nxt; sh_r <= sh_nxt; zero_r <= zero_nxt;
    q_r <= q_nxt; res_r <= res_nxt;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data  = res_r;
endmodule

// File: rtl/dlf_checker.sv
// Port-level checker for dense_layer_forward, bound to the top level.
// Depends on dlf_pkg and the dlf_*_if interfaces.
module dlf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_ready,
  input dlf_pkg::out_item_t out_data
);
  import dlf_pkg::*;

  // A result held back by the sink keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The block takes no items while a result other than the last one is pending.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_output |-> !in_ready)
    else $error("input ready during output");

  // Input and configuration are ready together.
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == cfg_ready) else $error("ready mismatch");

  // A taken result leaves the output register empty in the next cycle.
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("result register refilled in the beat cycle");
endmodule

bind dense_layer_forward dlf_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .cfg_ready(cfg_ch.ready), .out_data(out_ch.data));

// File: tb/tb_top.sv
// Self-checking testbench for dense_layer_forward: weight, bias and input beats in,
// per-neuron activations out, checked against a local fixed-point layer predictor.
// Depends on dlf_pkg, the dlf_*_if interfaces and the dense_layer_forward RTL.
module tb_top;
  import dlf_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   items_sent;

  dlf_in_if  in_ch ();
  dlf_out_if out_ch ();
  dlf_cfg_if cfg_ch ();

  dense_layer_forward dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Local copy of the layer state and registers.
  logic signed [15:0] weight_mem [WeightDepth];
  bit                 weight_set [WeightDepth];
  logic signed [15:0] bias_mem [MaxOutputs];
  bit                 bias_set [MaxOutputs];
  logic signed [15:0] input_mem [MaxInputs];
  bit                 input_set [MaxInputs];
  logic               mode_reg;
  logic [6:0]         nin_reg;
  logic [6:0]         nout_reg;
  out_item_t          pending_acts [$];

  // Clock: period 20.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int clamp_count(logic [6:0] r, int hi);
    if (r < 1) return 1;
    if (r > hi) return hi;
    return r;
  endfunction

  // Quadratic base-two exponential of a non-positive Q20.12 difference.
  function automatic longint exp_q12(longint d);
    longint t, k, f, p;
    t = (d * 5909) >>> 12;
    k = t >>> 12;
    f = t - k * 4096;
    if (-k >= 14) return 0;
    p = 4096 + ((f * (2689 + ((f * 1407) >>> 12))) >>> 12);
    return p >> (-k);
  endfunction

  // Forward pass over the whole layer; queues one activation per neuron.
  task automatic predict_layer();
    longint    z [MaxOutputs];
    longint    e [MaxOutputs];
    longint    acc, zmax, sum, a;
    int        ni, no;
    out_item_t act;
    ni = clamp_count(nin_reg, MaxInputs);
    no = clamp_count(nout_reg, MaxOutputs);
    for (int n = 0; n < no; n++) begin
      acc = 0;
      for (int j = 0; j < ni; j++)
        acc += longint'(weight_mem[n * ni + j]) * longint'(input_mem[j]);
      z[n] = (acc >>> 12) + longint'(bias_mem[n]);
      if (z[n] > 64'sd2147483647) z[n] = 64'sd2147483647;
      if (z[n] < -64'sd2147483648) z[n] = -64'sd2147483648;
    end
    zmax = z[0];
    sum = 0;
    if (mode_reg) begin
      for (int n = 1; n < no; n++)
        if (z[n] > zmax) zmax = z[n];
      for (int n = 0; n < no; n++) begin
        e[n] = exp_q12(z[n] - zmax);
        sum += e[n];
      end
    end
    for (int n = 0; n < no; n++) begin
      if (mode_reg) a = (e[n] * 4096 + (sum >> 1)) / sum;
      else a = (z[n] <= 0) ? 0 : ((z[n] > 32767) ? 32767 : z[n]);
      act.neuron_index = n[5:0];
      act.activation   = a[14:0];
      act.last_output  = (n == no - 1);
      pending_acts.push_back(act);
    end
  endtask

  // Update the local state for one accepted input beat.
  task automatic apply_item(in_item_t it);
    case (it.operation)
      OP_WEIGHT: begin
        weight_mem[it.index] = it.value;
        weight_set[it.index] = 1'b1;
      end
      OP_BIAS: begin
        if (it.index < MaxOutputs) begin
          bias_mem[it.index] = it.value;
          bias_set[it.index] = 1'b1;
        end
      end
      OP_INPUT: begin
        if (it.index < MaxInputs) begin
          input_mem[it.index] = it.value;
          input_set[it.index] = 1'b1;
        end
        if (it.index == clamp_count(nin_reg, MaxInputs) - 1) predict_layer();
      end
      default: ;
    endcase
  endtask

  // Send one input beat, with an optional random gap in front of it.
  task automatic send_item(op_t op, int idx, logic [15:0] val);
    in_item_t it;
    it.operation = op;
    it.index     = idx[11:0];
    it.value     = val;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    apply_item(it);
  endtask

  // Hold off until every expected activation has arrived and the block is quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_acts.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t r, logic [6:0] d);
    cfg_item_t c;
    settle();
    c.index = r;
    c.data  = d;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= c;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (r)
      REG_MODE: mode_reg = d[0];
      REG_NIN:  nin_reg  = d;
      REG_NOUT: nout_reg = d;
      default: ;
    endcase
  endtask

  task automatic set_layer(logic mode, logic [6:0] nin, logic [6:0] nout);
    write_reg(REG_MODE, {6'd0, mode});
    write_reg(REG_NIN, nin);
    write_reg(REG_NOUT, nout);
  endtask

  function automatic logic [15:0] rand_value();
    if ($urandom_range(1)) return 16'($urandom_range(16'hFFFF));
    return 16'($signed($urandom_range(4095)) - 2048);
  endfunction

  // Fill every entry the next pass reads that has not been written yet, but for the last input element.
  task automatic fill_layer();
    int ni, no;
    ni = clamp_count(nin_reg, MaxInputs);
    no = clamp_count(nout_reg, MaxOutputs);
    for (int k = 0; k < ni * no; k++)
      if (!weight_set[k]) send_item(OP_WEIGHT, k, rand_value());
    for (int n = 0; n < no; n++)
      if (!bias_set[n]) send_item(OP_BIAS, n, rand_value());
    for (int j = 0; j < ni - 1; j++)
      if (!input_set[j]) send_item(OP_INPUT, j, rand_value());
  endtask

  // Deliver a whole input vector in order; the last element fires the pass.
  task automatic send_vector();
    int ni;
    ni = clamp_count(nin_reg, MaxInputs);
    for (int j = 0; j < ni; j++) send_item(OP_INPUT, j, rand_value());
  endtask

  // Directed corners: extreme values in both modes, ignored beats.
  task automatic test_directed_edges();
    set_layer(1'b0, 7'd1, 7'd1);
    send_item(OP_BIAS, 0, 16'h8000);
    send_item(OP_WEIGHT, 0, 16'h7FFF);
    send_item(OP_INPUT, 0, 16'h7FFF);
    send_item(OP_WEIGHT, 0, 16'h8000);
    send_item(OP_INPUT, 0, 16'h8000);
    send_item(OP_BIAS, 0, 16'h7FFF);
    send_item(OP_INPUT, 0, 16'h0000);
    send_item(OP_WEIGHT, 0, 16'h7FFF);
    send_item(OP_INPUT, 0, 16'h8000);
    send_item(OP_RESERVED, 4095, 16'hFFFF);
    send_item(OP_BIAS, 100, 16'h1234);
    send_item(OP_INPUT, 4095, 16'h5555);
    send_item(OP_WEIGHT, 4095, 16'hAAAA);
    set_layer(1'b1, 7'd2, 7'd4);
    fill_layer();
    send_item(OP_BIAS, 0, 16'h7FFF);
    send_item(OP_BIAS, 3, 16'h8000);
    send_vector();
    send_item(OP_INPUT, 1, 16'h0001);
  endtask

  // Count registers out of range saturate, at both ends of each range.
  task automatic test_count_saturation();
    set_layer(1'b0, 7'd0, 7'd0);
    fill_layer();
    send_vector();
    set_layer(1'b0, 7'd0, 7'd127);
    fill_layer();
    send_vector();
    set_layer(1'b1, 7'd0, 7'd127);
    send_vector();
    set_layer(1'b1, 7'd127, 7'd0);
    fill_layer();
    send_item(OP_INPUT, MaxInputs - 1, rand_value());
  endtask

  // Random layers: mostly well-formed vectors, with updates and noise mixed in.
  task automatic test_random_traffic(int target);
    int ni, roll, no_out, start_count;
    start_count = items_sent;
    while (items_sent - start_count < target) begin
      roll = $urandom_range(9);
      no_out = (roll == 0) ? $urandom_range(16, 64) :
               ((roll == 1) ? 1 : $urandom_range(1, 8));
      ni = (roll == 1) ? $urandom_range(16, 32) :
           ((roll == 0) ? 1 : $urandom_range(1, 8));
      set_layer(1'($urandom_range(1)), ni[6:0], no_out[6:0]);
      fill_layer();
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 4)) begin
          roll = $urandom_range(9);
          if (roll < 5) send_item(OP_WEIGHT, $urandom_range(ni * no_out - 1), rand_value());
          else if (roll < 8) send_item(OP_BIAS, $urandom_range(no_out - 1), rand_value());
          else if (roll == 8) send_item(OP_RESERVED, $urandom_range(4095), rand_value());
          else send_item(OP_INPUT, $urandom_range(64, 4095), rand_value());
        end
        if ($urandom_range(4) == 0)
          send_item(OP_INPUT, $urandom_range(ni - 1), rand_value());
        send_vector();
      end
    end
  endtask

  // Result side: random back-pressure and a check on every beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_acts.size() == 0) begin
          $error("unexpected result beat: neuron %0d", out_ch.data.neuron_index);
          fail_count++;
        end else begin
          out_item_t want;
          want = pending_acts.pop_front();
          if (out_ch.data.neuron_index !== want.neuron_index) begin
            $error("neuron_index: expected %0d, got %0d",
                   want.neuron_index, out_ch.data.neuron_index);
            fail_count++;
          end
          if (out_ch.data.activation !== want.activation) begin
            $error("activation: expected %0d, got %0d",
                   want.activation, out_ch.data.activation);
            fail_count++;
          end
          if (out_ch.data.last_output !== want.last_output) begin
            $error("last_output: expected %0d, got %0d",
                   want.last_output, out_ch.data.last_output);
            fail_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Main sequence.
  initial begin
    fail_count     = 0;
    items_sent     = 0;
    send_idle_pct  = 19;
    recv_stall_pct = 66;
    mode_reg = 1'b0;
    nin_reg  = 7'd64;
    nout_reg = 7'd64;
    for (int k = 0; k < WeightDepth; k++) weight_set[k] = 1'b0;
    for (int k = 0; k < MaxOutputs; k++) bias_set[k] = 1'b0;
    for (int k = 0; k < MaxInputs; k++) input_set[k] = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_count_saturation();
    test_random_traffic(20);
    settle();
    send_idle_pct  = 66;
    recv_stall_pct = 19;
    test_random_traffic(20);
    settle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(20);
    settle();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("** dense_layer_forward: PASSED **");
    end else begin
      $display("** dense_layer_forward: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #40000000;
    $display("** dense_layer_forward: FAILED **");
    $finish;
  end
endmodule
